### hdl/ihdp_pkg.sv
// ----------------------------------------------------------------------------
// Image header dimension parser package
// Shared types, format codes and signature bytes for the header parser.
// ----------------------------------------------------------------------------
package ihdp_pkg;

	localparam int CountWidthDef = 32;
	localparam int HdrDepth      = 30;
	localparam int HdrIdxW       = $clog2(HdrDepth);
	localparam int WinDepth      = 10;
	localparam int DimW          = 32;
	localparam int FmtW          = 3;

	localparam logic [FmtW-1:0] FmtNone = 3'd0;
	localparam logic [FmtW-1:0] FmtPng  = 3'd1;
	localparam logic [FmtW-1:0] FmtJpeg = 3'd2;
	localparam logic [FmtW-1:0] FmtGif  = 3'd3;
	localparam logic [FmtW-1:0] FmtWebp = 3'd4;
	localparam logic [FmtW-1:0] FmtBmp  = 3'd5;

	localparam logic [31:0] PngSig    = 32'h89504E47;
	localparam logic [7:0]  JpegMark  = 8'hFF;
	localparam logic [7:0]  JpegSoi   = 8'hD8;
	localparam logic [7:0]  JpegSof0  = 8'hC0;
	localparam logic [7:0]  JpegSof2  = 8'hC2;
	localparam logic [13:0] VpDimMask = 14'h3FFF;

	typedef logic [HdrDepth-1:0][7:0] hdr_t;
	typedef logic [WinDepth-1:0][7:0] win_t;

	typedef struct packed {
		logic short_file;
		logic ge24;
		logic ge26;
		logic ge30;
	} len_t;

endpackage

### hdl/image_header_dimension_parser_unit.sv
// ----------------------------------------------------------------------------
// Image header dimension parser
// A final item passes the input register and then the result register.
// Throughput: one byte per cycle, set by the input register and one pass of
// header capture, marker walk and decode before the result register. A final
// item waits in the input register while the previous result is still unread.
// Reset: arst_n clears all control state; state also clears after each file.
// ----------------------------------------------------------------------------
module image_header_dimension_parser_unit
	import ihdp_pkg::*;
#(
	parameter int COUNT_WIDTH = CountWidthDef
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             data_byte,
	input  logic                   last_byte,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [FmtW-1:0]        format,
	output logic signed [DimW-1:0] width,
	output logic signed [DimW-1:0] height,
	output logic [31:0]            byte_count
);

	localparam int CmpW = (COUNT_WIDTH > 33) ? COUNT_WIDTH : 33;
	localparam int ExtW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   last_s1;
	logic                   advance;

	hdr_t                   hdr_q;
	hdr_t                   hdr_v;
	win_t                   win_q;
	win_t                   win_d;
	logic [COUNT_WIDTH-1:0] bytes_q;
	logic [COUNT_WIDTH-1:0] bytes_d;
	logic [31:0]            pos_q;
	logic [31:0]            pos_d;
	logic                   walk_q;
	logic                   walk_d;
	logic [15:0]            sof_w_q;
	logic [15:0]            sof_w_d;
	logic [15:0]            sof_h_q;
	logic [15:0]            sof_h_d;
	logic                   hdr_wr;
	logic                   walk_hit;
	logic [32:0]            next_pos;
	logic [ExtW-1:0]        n_ext;
	len_t                   len;

	logic [FmtW-1:0]        fmt_c;
	logic signed [DimW-1:0] wd_c;
	logic signed [DimW-1:0] ht_c;

	logic                   out_valid_q;
	logic [FmtW-1:0]        format_q;
	logic signed [DimW-1:0] width_q;
	logic signed [DimW-1:0] height_q;
	logic [31:0]            count_q;

	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	assign hdr_wr = bytes_q < COUNT_WIDTH'(HdrDepth);
	assign win_d  = {byte_s1, win_q[WinDepth-1:1]};

	always_comb begin
		for (int k = 0; k < HdrDepth; k++) begin
			hdr_v[k] = (hdr_wr && bytes_q[HdrIdxW-1:0] == HdrIdxW'(k)) ? byte_s1 : hdr_q[k];
		end
	end

	assign bytes_d  = (&bytes_q) ? bytes_q : bytes_q + COUNT_WIDTH'(1);
	assign walk_hit = walk_q && (CmpW'(bytes_q) == CmpW'({1'b0, pos_q} + 33'd9));
	assign next_pos = {1'b0, pos_q} + 33'({win_d[2], win_d[3]}) + 33'd2;

	always_comb begin
		pos_d   = pos_q;
		walk_d  = walk_q;
		sof_w_d = sof_w_q;
		sof_h_d = sof_h_q;
		if (walk_hit) begin
			if (win_d[0] != JpegMark) begin
				walk_d = 1'b0;
			end else if (win_d[1] == JpegSof0 || win_d[1] == JpegSof2) begin
				sof_h_d = {win_d[5], win_d[6]};
				sof_w_d = {win_d[7], win_d[8]};
				walk_d  = 1'b0;
			end else if (next_pos[32]) begin
				walk_d = 1'b0;
			end else begin
				pos_d = next_pos[31:0];
			end
		end
	end

	assign len.short_file = bytes_d < COUNT_WIDTH'(16);
	assign len.ge24       = bytes_d >= COUNT_WIDTH'(24);
	assign len.ge26       = bytes_d >= COUNT_WIDTH'(26);
	assign len.ge30       = bytes_d >= COUNT_WIDTH'(30);
	assign n_ext          = ExtW'(bytes_d);

	ihdp_decode u_decode (
		.hdr        (hdr_v),
		.len        (len),
		.sof_width  (sof_w_d),
		.sof_height (sof_h_d),
		.format     (fmt_c),
		.width      (wd_c),
		.height     (ht_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q <= '0;
			pos_q   <= 32'd2;
			walk_q  <= 1'b1;
			sof_w_q <= '0;
			sof_h_q <= '0;
		end else if (advance) begin
			if (last_s1) begin
				bytes_q <= '0;
				pos_q   <= 32'd2;
				walk_q  <= 1'b1;
				sof_w_q <= '0;
				sof_h_q <= '0;
			end else begin
				bytes_q <= bytes_d;
				pos_q   <= pos_d;
				walk_q  <= walk_d;
				sof_w_q <= sof_w_d;
				sof_h_q <= sof_h_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			win_q <= win_d;
			if (hdr_wr) begin
				hdr_q[bytes_q[HdrIdxW-1:0]] <= byte_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			format_q <= fmt_c;
			width_q  <= wd_c;
			height_q <= ht_c;
			if (len.short_file) begin
				count_q <= '0;
			end else if (n_ext > ExtW'(32'hFFFF_FFFF)) begin
				count_q <= '1;
			end else begin
				count_q <= n_ext[31:0];
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign format     = format_q;
	assign width      = width_q;
	assign height     = height_q;
	assign byte_count = count_q;

endmodule

### hdl/ihdp_decode.sv
// ----------------------------------------------------------------------------
// Image header decoder
// Picks the format from the stored header bytes and extracts the dimensions.
// ----------------------------------------------------------------------------
module ihdp_decode
	import ihdp_pkg::*;
(
	input  hdr_t                   hdr,
	input  len_t                   len,
	input  logic [15:0]            sof_width,
	input  logic [15:0]            sof_height,
	output logic [FmtW-1:0]        format,
	output logic signed [DimW-1:0] width,
	output logic signed [DimW-1:0] height
);

	logic [31:0] vp8l_bits;

	assign vp8l_bits = {hdr[24], hdr[23], hdr[22], hdr[21]};

	always_comb begin
		format = FmtNone;
		width  = '0;
		height = '0;
		if (len.short_file) begin
			format = FmtNone;
		end else if (len.ge24 && {hdr[0], hdr[1], hdr[2], hdr[3]} == PngSig) begin
			format = FmtPng;
			width  = {hdr[16], hdr[17], hdr[18], hdr[19]};
			height = {hdr[20], hdr[21], hdr[22], hdr[23]};
		end else if (hdr[0] == JpegMark && hdr[1] == JpegSoi) begin
			format = FmtJpeg;
			width  = {16'h0000, sof_width};
			height = {16'h0000, sof_height};
		end else if ({hdr[0], hdr[1], hdr[2]} == "GIF") begin
			format = FmtGif;
			width  = {16'h0000, hdr[7], hdr[6]};
			height = {16'h0000, hdr[9], hdr[8]};
		end else if (len.ge30 && {hdr[0], hdr[1], hdr[2], hdr[3]} == "RIFF"
				&& {hdr[8], hdr[9], hdr[10], hdr[11]} == "WEBP") begin
			format = FmtWebp;
			if ({hdr[12], hdr[13], hdr[14]} == "VP8") begin
				if (hdr[15] == " ") begin
					width  = {16'h0000, {hdr[27], hdr[26]} & {2'b00, VpDimMask}};
					height = {16'h0000, {hdr[29], hdr[28]} & {2'b00, VpDimMask}};
				end else if (hdr[15] == "L") begin
					width  = 32'(vp8l_bits[13:0]) + 32'd1;
					height = 32'(vp8l_bits[27:14]) + 32'd1;
				end else if (hdr[15] == "X") begin
					width  = {8'h00, hdr[26], hdr[25], hdr[24]} + 32'd1;
					height = {8'h00, hdr[29], hdr[28], hdr[27]} + 32'd1;
				end
			end
		end else if (len.ge26 && {hdr[0], hdr[1]} == "BM") begin
			format = FmtBmp;
			width  = {hdr[21], hdr[20], hdr[19], hdr[18]};
			height = {hdr[25], hdr[24], hdr[23], hdr[22]};
		end
	end

endmodule

### test/image_header_dimension_parser_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image header dimension parser testbench
// Streams synthetic PNG, JPEG, GIF, WebP, BMP and noise files into the parser
// one byte per item. A byte-level model of the header sniffer predicts the
// result on each final byte, and every result is checked in order. Both sides
// idle at random, and the result side also stalls for long stretches.
// ----------------------------------------------------------------------------
module image_header_dimension_parser_unit_test
	import ihdp_pkg::*;
();

	localparam int              ClkPeriod = 20;
	localparam int              CountW    = CountWidthDef;
	localparam longint unsigned CountMax  = (64'd1 << CountW) - 64'd1;

	typedef struct {
		logic [FmtW-1:0]        fmt;
		logic signed [DimW-1:0] wd;
		logic signed [DimW-1:0] ht;
		logic [31:0]            cnt;
	} dims_t;

	typedef enum int {KindPng, KindJpeg, KindGif, KindWebp, KindBmp, KindNoise} file_kind_e;
	typedef enum int {JpegClean, JpegNoSof, JpegBadMarker, JpegCut} jpeg_flaw_e;
	typedef enum int {ChunkLossy, ChunkLossless, ChunkExtended, ChunkOddVp8, ChunkOther}
		webp_chunk_e;

	logic                   clk        = 1'b0;
	logic                   arst_n     = 1'b0;
	logic                   in_valid   = 1'b0;
	logic                   in_ready;
	logic [7:0]             data_byte  = 8'h00;
	logic                   last_byte  = 1'b0;
	logic                   out_valid;
	logic                   out_ready  = 1'b0;
	logic [FmtW-1:0]        format;
	logic signed [DimW-1:0] width;
	logic signed [DimW-1:0] height;
	logic [31:0]            byte_count;

	logic [7:0]      hdr_img [HdrDepth];
	logic [7:0]      seg_win [WinDepth];
	longint unsigned img_len;
	longint unsigned seg_pos;
	bit              seg_walk;
	logic [15:0]     sof_wd;
	logic [15:0]     sof_ht;

	dims_t      dims_q[$];
	logic [7:0] file_q[$];
	int         send_idle  = 14;
	int         recv_idle  = 82;
	int         hold_left  = 0;
	int         mismatches = 0;

	image_header_dimension_parser_unit #(
		.COUNT_WIDTH(CountW)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.format    (format),
		.width     (width),
		.height    (height),
		.byte_count(byte_count)
	);

	always #(ClkPeriod / 2) clk = ~clk;

	function automatic void clear_sniffer();
		foreach (hdr_img[k]) hdr_img[k] = '0;
		foreach (seg_win[k]) seg_win[k] = '0;
		img_len  = 0;
		seg_pos  = 2;
		seg_walk = 1'b1;
		sof_wd   = '0;
		sof_ht   = '0;
	endfunction

	function automatic logic [31:0] hdr_le(int k, int nb);
		logic [31:0] v;
		int          j;
		v = '0;
		for (j = 0; j < nb; j++) v[8*j +: 8] = hdr_img[k + j];
		return v;
	endfunction

	function automatic bit hdr_is(int k, string s);
		int j;
		for (j = 0; j < s.len(); j++) begin
			if (hdr_img[k + j] != s[j]) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic bit sniff_byte(input logic [7:0] b, input bit lb, output dims_t res);
		longint unsigned pos;
		longint unsigned nxt;
		logic [31:0]     bits;
		int              j;
		res = '{default: '0};
		pos = img_len;
		if (pos < HdrDepth) hdr_img[pos] = b;
		for (j = 0; j < WinDepth - 1; j++) seg_win[j] = seg_win[j + 1];
		seg_win[WinDepth - 1] = b;
		if (seg_walk && pos == seg_pos + 9) begin
			if (seg_win[0] != JpegMark) begin
				seg_walk = 1'b0;
			end else if (seg_win[1] == JpegSof0 || seg_win[1] == JpegSof2) begin
				sof_ht   = {seg_win[5], seg_win[6]};
				sof_wd   = {seg_win[7], seg_win[8]};
				seg_walk = 1'b0;
			end else begin
				nxt = seg_pos + {seg_win[2], seg_win[3]} + 2;
				if (nxt > 64'hFFFF_FFFF) seg_walk = 1'b0;
				else seg_pos = nxt;
			end
		end
		if (img_len < CountMax) img_len++;
		if (!lb) return 1'b0;
		if (img_len >= 16) begin
			res.cnt = (img_len > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : img_len[31:0];
			if (img_len >= 24 && {hdr_img[0], hdr_img[1], hdr_img[2], hdr_img[3]} == PngSig) begin
				res.fmt = FmtPng;
				res.wd  = {hdr_img[16], hdr_img[17], hdr_img[18], hdr_img[19]};
				res.ht  = {hdr_img[20], hdr_img[21], hdr_img[22], hdr_img[23]};
			end else if (hdr_img[0] == JpegMark && hdr_img[1] == JpegSoi) begin
				res.fmt = FmtJpeg;
				res.wd  = {16'h0000, sof_wd};
				res.ht  = {16'h0000, sof_ht};
			end else if (hdr_is(0, "GIF")) begin
				res.fmt = FmtGif;
				res.wd  = hdr_le(6, 2);
				res.ht  = hdr_le(8, 2);
			end else if (img_len >= 30 && hdr_is(0, "RIFF") && hdr_is(8, "WEBP")) begin
				res.fmt = FmtWebp;
				if (hdr_is(12, "VP8 ")) begin
					res.wd = hdr_le(26, 2) & VpDimMask;
					res.ht = hdr_le(28, 2) & VpDimMask;
				end else if (hdr_is(12, "VP8L")) begin
					bits   = hdr_le(21, 4);
					res.wd = bits[13:0] + 1;
					res.ht = bits[27:14] + 1;
				end else if (hdr_is(12, "VP8X")) begin
					res.wd = hdr_le(24, 3) + 1;
					res.ht = hdr_le(27, 3) + 1;
				end
			end else if (img_len >= 26 && hdr_is(0, "BM")) begin
				res.fmt = FmtBmp;
				res.wd  = hdr_le(18, 4);
				res.ht  = hdr_le(22, 4);
			end
		end
		clear_sniffer();
		return 1'b1;
	endfunction

	function automatic void add_byte(logic [7:0] b);
		file_q = {file_q, b};
	endfunction

	function automatic void fill_file(int n, bit rnd, logic [7:0] v);
		file_q.delete();
		repeat (n) add_byte(rnd ? 8'($urandom_range(255)) : v);
	endfunction

	function automatic void put_word(int k, logic [31:0] v, int nb, bit big);
		int j;
		for (j = 0; j < nb; j++) file_q[k + j] = big ? v[8*(nb-1-j) +: 8] : v[8*j +: 8];
	endfunction

	function automatic void put_text(int k, string s);
		int j;
		for (j = 0; j < s.len(); j++) file_q[k + j] = s[j];
	endfunction

	function automatic void add_sof(logic [7:0] sof);
		add_byte(JpegMark);
		add_byte(sof);
		add_byte(8'h00);
		add_byte(8'h11);
		add_byte(8'h08);
		repeat ($urandom_range(5, 12)) add_byte(8'($urandom_range(255)));
	endfunction

	function automatic void make_png(int n);
		fill_file(n, 1'b1, 8'h00);
		put_word(0, PngSig, 4, 1'b1);
	endfunction

	function automatic void make_gif(int n);
		fill_file(n, 1'b1, 8'h00);
		put_text(0, "GIF");
	endfunction

	function automatic void make_bmp(int n);
		fill_file(n, 1'b1, 8'h00);
		put_text(0, "BM");
	endfunction

	function automatic void make_webp(int n, webp_chunk_e chunk);
		fill_file(n, 1'b1, 8'h00);
		put_text(0, "RIFF");
		put_text(8, "WEBP");
		case (chunk)
		ChunkLossy: put_text(12, "VP8 ");
		ChunkLossless: put_text(12, "VP8L");
		ChunkExtended: put_text(12, "VP8X");
		ChunkOddVp8: put_text(12, "VP8");
		default: ;
		endcase
	endfunction

	function automatic void make_jpeg(jpeg_flaw_e flaw, logic [7:0] sof, int nseg);
		logic [7:0] mk;
		int         seg_len;
		int         cut;
		file_q = {JpegMark, JpegSoi};
		repeat (nseg) begin
			mk = 8'($urandom_range(255));
			if (mk == JpegSof0 || mk == JpegSof2) mk++;
			seg_len = ($urandom_range(15) == 0) ? $urandom_range(2, 400) : $urandom_range(2, 20);
			if (flaw != JpegClean && $urandom_range(3) == 0) seg_len = $urandom_range(65535);
			add_byte(JpegMark);
			add_byte(mk);
			add_byte(seg_len[15:8]);
			add_byte(seg_len[7:0]);
			repeat ((seg_len < 2) ? 0 : (seg_len > 400) ? 6 : seg_len - 2)
				add_byte(8'($urandom_range(255)));
		end
		if (flaw != JpegNoSof) add_sof(sof);
		if (flaw == JpegBadMarker) file_q[2] = 8'($urandom_range(8'hFE));
		if (flaw == JpegCut) begin
			cut = $urandom_range(4, 14);
			while (cut > 0 && file_q.size() > 1) begin
				void'(file_q.pop_back());
				cut--;
			end
		end
		if (flaw == JpegClean || $urandom_range(3) != 0) begin
			while (file_q.size() < 16) add_byte(8'($urandom_range(255)));
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit lb);
		dims_t res;
		while ($urandom_range(99) < send_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid  = 1'b1;
		data_byte = b;
		last_byte = lb;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (sniff_byte(b, lb, res)) dims_q = {dims_q, res};
		@(negedge clk);
	endtask

	task automatic send_file();
		int i;
		for (i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
	endtask

	task automatic wait_results();
		in_valid = 1'b0;
		while (dims_q.size() != 0) @(negedge clk);
	endtask

	task automatic set_idle(int snd, int rcv);
		in_valid = 1'b0;
		@(posedge clk);
		send_idle = snd;
		recv_idle = rcv;
		@(negedge clk);
	endtask

	task automatic test_short_files();
		file_q = {8'h00};
		send_file();
		file_q = {8'hFF};
		send_file();
		make_png(15);
		send_file();
		fill_file(16, 1'b0, 8'hFF);
		send_file();
		fill_file(16, 1'b0, 8'h00);
		send_file();
	endtask

	task automatic test_png();
		fill_file(24, 1'b0, 8'h00);
		put_word(0, PngSig, 4, 1'b1);
		put_word(16, 32'hFFFF_FFFF, 4, 1'b1);
		put_word(20, 32'h8000_0000, 4, 1'b1);
		send_file();
		make_png(40);
		put_word(16, 32'h7FFF_FFFF, 4, 1'b1);
		put_word(20, 32'h0000_0000, 4, 1'b1);
		send_file();
		make_png(23);
		send_file();
	endtask

	task automatic test_jpeg();
		file_q = {JpegMark, JpegSoi, JpegMark, JpegSof0, 8'h00, 8'h11, 8'h08,
			8'h00, 8'h01, 8'hFF, 8'hFF};
		repeat (5) add_byte(8'h00);
		send_file();
		make_jpeg(JpegClean, JpegSof2, 1);
		send_file();
		make_jpeg(JpegNoSof, JpegSof0, 2);
		send_file();
		make_jpeg(JpegBadMarker, JpegSof0, 1);
		send_file();
		make_jpeg(JpegCut, JpegSof2, 0);
		send_file();
		file_q = {JpegMark, JpegSoi, JpegMark, 8'hE1, 8'h01, 8'h00};
		repeat (254) add_byte(8'($urandom_range(255)));
		add_sof(JpegSof0);
		send_file();
	endtask

	task automatic test_gif();
		make_gif(16);
		put_word(6, 32'h0000_FFFF, 2, 1'b0);
		put_word(8, 32'h0000_0000, 2, 1'b0);
		send_file();
		make_gif(12);
		send_file();
	endtask

	task automatic test_webp();
		make_webp(30, ChunkLossy);
		put_word(26, 32'h0000_FFFF, 2, 1'b0);
		put_word(28, 32'h0000_C001, 2, 1'b0);
		send_file();
		make_webp(30, ChunkLossless);
		put_word(21, 32'hFFFF_FFFF, 4, 1'b0);
		send_file();
		make_webp(30, ChunkExtended);
		put_word(24, 32'hFFFF_FFFF, 3, 1'b0);
		put_word(27, 32'h0000_0000, 3, 1'b0);
		send_file();
		make_webp(32, ChunkOddVp8);
		send_file();
		make_webp(29, ChunkLossy);
		send_file();
	endtask

	task automatic test_bmp();
		make_bmp(26);
		put_word(18, 32'h8000_0000, 4, 1'b0);
		put_word(22, 32'hFFFF_FFFF, 4, 1'b0);
		send_file();
		make_bmp(48);
		put_word(18, 32'h7FFF_FFFF, 4, 1'b0);
		put_word(22, 32'h0000_0000, 4, 1'b0);
		send_file();
		make_bmp(25);
		send_file();
	endtask

	// The result side is held off while single-byte files keep arriving, so the
	// parser fills up and must stall its input.
	task automatic test_output_stall();
		int f;
		in_valid = 1'b0;
		@(posedge clk);
		hold_left = 300;
		@(negedge clk);
		for (f = 0; f < 16; f++) begin
			file_q = {8'($urandom_range(255))};
			send_file();
		end
		make_png(30);
		send_file();
		make_jpeg(JpegClean, JpegSof0, 1);
		send_file();
		wait_results();
	endtask

	task automatic test_random_files(int snd, int rcv, int nfiles);
		int f;
		bit broken;
		set_idle(snd, rcv);
		for (f = 0; f < nfiles; f++) begin
			broken = ($urandom_range(4) == 0);
			case (file_kind_e'($urandom_range(KindNoise)))
			KindPng: make_png(broken ? $urandom_range(16, 23) : $urandom_range(24, 40));
			KindJpeg: make_jpeg(broken ? jpeg_flaw_e'($urandom_range(JpegNoSof, JpegCut)) : JpegClean,
				$urandom_range(1) ? JpegSof2 : JpegSof0, $urandom_range(3));
			KindGif: make_gif(broken ? $urandom_range(1, 15) : $urandom_range(16, 40));
			KindWebp: make_webp(broken ? $urandom_range(16, 29) : $urandom_range(30, 48),
				webp_chunk_e'($urandom_range(ChunkOther)));
			KindBmp: make_bmp(broken ? $urandom_range(16, 25) : $urandom_range(26, 48));
			default: fill_file($urandom_range(1, 48), 1'b1, 8'h00);
			endcase
			if ($urandom_range(15) == 0) begin
				repeat ($urandom_range(30, 250)) add_byte(8'($urandom_range(255)));
			end
			send_file();
		end
		wait_results();
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else begin
			out_ready = ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin : check_results
		dims_t want;
		if (arst_n && out_valid && out_ready) begin
			if (dims_q.size() == 0) begin
				$error("unexpected result: format %0d width %0d height %0d byte_count %0d",
					format, width, height, byte_count);
				mismatches++;
			end else begin
				want = dims_q[0];
				dims_q.delete(0);
				if (format !== want.fmt) begin
					$error("format: expected %0d, got %0d", want.fmt, format);
					mismatches++;
				end
				if (width !== want.wd) begin
					$error("width: expected %0d, got %0d", want.wd, width);
					mismatches++;
				end
				if (height !== want.ht) begin
					$error("height: expected %0d, got %0d", want.ht, height);
					mismatches++;
				end
				if (byte_count !== want.cnt) begin
					$error("byte_count: expected %0d, got %0d", want.cnt, byte_count);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		clear_sniffer();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_short_files();
		test_png();
		test_jpeg();
		test_gif();
		test_webp();
		test_bmp();
		test_output_stall();
		test_random_files(14, 82, 3);
		test_random_files(82, 14, 3);
		test_random_files(0, 0, 3);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
